@@ rtl/bptms_pkg.sv @@
package bptms_pkg;

  // Operation codes carried in the func field
  typedef enum logic [1:0] {
    FUNC_TOUCH = 2'd0,
    FUNC_BEGIN = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  // Kind of result loaded into the output register
  typedef enum logic [1:0] {
    RES_PLAIN = 2'd0,
    RES_HIT   = 2'd1,
    RES_NEW   = 2'd2,
    RES_FULL  = 2'd3
  } res_e;

  // Input transaction layout
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned FIELD_ID_W  = 16;
  localparam int unsigned SLOT_W      = 8;
  localparam int unsigned CNT_W       = 9;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // latch key, clear index and removed count
    logic clr_marks;  // clear all visited marks
    logic rd_i;       // read key memory at index
    logic rd_last;    // read key memory at last entry
    logic i_inc;      // advance index
    logic mark_hit;   // mark entry at index visited
    logic append;     // write key at end, mark it, grow count
    logic move;       // copy last entry into index slot, shrink count
    logic drop_last;  // remove last entry, which is the index slot
    logic res_load;   // load output register
    res_e res_kind;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic i_lt_count;
    logic i_is_last;
    logic mark_i;
    logic match;
    logic full;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/body_pair_table_mark_sweep_top.sv @@
// Pair table with mark-and-sweep retirement. Each input transaction carries a func
// code: touch finds or appends the ordered id pair, marks it and returns its slot;
// begin frame clears all marks; end frame sweeps out unmarked entries, filling each
// hole with the last entry, and reports removed and live counts. One item is handled
// at a time through a single-port key memory with registered read: a touch reads and
// compares the entries in a linear search and, on a miss, appends the pair or is
// refused when the table is full; an end frame steps past each kept entry, drops an
// unmarked last entry, and fills any other hole by reading the last entry and moving it.
// A result waits in an output register while the next item is accepted. No clearing
// pass after reset.
module body_pair_table_mark_sweep_top
  import bptms_pkg::*;
#(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned ID_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // func[1:0], body_a[17:2], body_b[33:18]
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o   // slot[7:0], created[8], full_res[9],
                                                  // live_count[18:10], removed_count[27:19]
);

  cmd_t                  cmd;
  sts_t                  sts;
  func_e                 func;
  logic [SLOT_W-1:0]     slot;
  logic                  created, full_res;
  logic [CNT_W-1:0]      live_count, removed_count;

  assign func = func_e'(s_axis_tdata_i[1:0]);

  bptms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_func_i  (func),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  bptms_dpath #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .body_a_i        (s_axis_tdata_i[17:2]),
    .body_b_i        (s_axis_tdata_i[33:18]),
    .cmd_i           (cmd),
    .out_ready_i     (m_axis_tready_i),
    .sts_o           (sts),
    .out_valid_o     (m_axis_tvalid_o),
    .slot_o          (slot),
    .created_o       (created),
    .full_res_o      (full_res),
    .live_count_o    (live_count),
    .removed_count_o (removed_count)
  );

  assign m_axis_tdata_o = {4'b0, removed_count, live_count, full_res, created, slot};

  // Only one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted twice in a row");

  // Refused pair reports neither creation nor a slot
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && full_res |-> !created && slot == '0)
    else $error("full result with slot or created set");

  // A result is never loaded over a pending one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> !(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("output register overwritten");

endmodule

@@ rtl/bptms_ctrl.sv @@
module bptms_ctrl
  import bptms_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  func_e in_func_i,
  input  sts_t  sts_i,
  output logic  in_ready_o,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_T_RD,
    ST_T_CMP,
    ST_S_CHK,
    ST_S_MOVE,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  res_e   kind_q, kind_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Sequence one item at a time
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.res_kind = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          kind_d = RES_PLAIN;
          unique case (in_func_i)
            FUNC_TOUCH: state_d = ST_T_RD;
            FUNC_BEGIN: begin
              cmd_o.clr_marks = 1'b1;
              state_d = ST_OUT;
            end
            FUNC_END:   state_d = ST_S_CHK;
            default:    state_d = ST_OUT;
          endcase
        end
      end
      ST_T_RD: begin
        priority if (sts_i.i_lt_count) begin
          cmd_o.rd_i = 1'b1;
          state_d = ST_T_CMP;
        end else if (sts_i.full) begin
          kind_d = RES_FULL;
          state_d = ST_OUT;
        end else begin
          cmd_o.append = 1'b1;
          kind_d = RES_NEW;
          state_d = ST_OUT;
        end
      end
      ST_T_CMP: begin
        if (sts_i.match) begin
          cmd_o.mark_hit = 1'b1;
          kind_d = RES_HIT;
          state_d = ST_OUT;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d = ST_T_RD;
        end
      end
      ST_S_CHK: begin
        priority if (!sts_i.i_lt_count) begin
          state_d = ST_OUT;
        end else if (sts_i.mark_i) begin
          cmd_o.i_inc = 1'b1;
        end else if (sts_i.i_is_last) begin
          cmd_o.drop_last = 1'b1;
        end else begin
          cmd_o.rd_last = 1'b1;
          state_d = ST_S_MOVE;
        end
      end
      ST_S_MOVE: begin
        cmd_o.move = 1'b1;
        state_d = ST_S_CHK;
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= RES_PLAIN;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

@@ rtl/bptms_dpath.sv @@
module bptms_dpath
  import bptms_pkg::*;
#(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned ID_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [FIELD_ID_W-1:0] body_a_i,
  input  logic [FIELD_ID_W-1:0] body_b_i,
  input  cmd_t                  cmd_i,
  input  logic                  out_ready_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic                  created_o,
  output logic                  full_res_o,
  output logic [CNT_W-1:0]      live_count_o,
  output logic [CNT_W-1:0]      removed_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = 2 * ID_BITS;

  logic [KW-1:0]       keys_mem [CAPACITY];
  logic [KW-1:0]       rdata_q;
  logic [KW-1:0]       key_q;
  logic [CAPACITY-1:0] marks_q;
  logic [CW-1:0]       count_q, i_q, removed_q;
  logic [CW-1:0]       last_w;
  logic [AW-1:0]       i_idx, last_idx;
  logic [31:0]         a32, b32;
  logic [ID_BITS-1:0]  a_m, b_m, lo_w, hi_w;
  logic [31:0]         slot32, live32, rem32;
  logic                out_valid_q;

  // Order the masked ids, smaller first
  assign a32  = 32'(body_a_i);
  assign b32  = 32'(body_b_i);
  assign a_m  = a32[ID_BITS-1:0];
  assign b_m  = b32[ID_BITS-1:0];
  assign lo_w = (a_m < b_m) ? a_m : b_m;
  assign hi_w = (a_m < b_m) ? b_m : a_m;

  assign last_w   = count_q - CW'(1);
  assign i_idx    = i_q[AW-1:0];
  assign last_idx = last_w[AW-1:0];

  assign sts_o.i_lt_count = (i_q < count_q);
  assign sts_o.i_is_last  = (i_q == last_w);
  assign sts_o.mark_i     = marks_q[i_idx];
  assign sts_o.match      = (rdata_q == key_q);
  assign sts_o.full       = (count_q == CW'(CAPACITY));
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) keys_mem[i_idx] <= key_q;
    if (cmd_i.move)   keys_mem[i_idx] <= rdata_q;
    if (cmd_i.rd_i)    rdata_q <= keys_mem[i_idx];
    if (cmd_i.rd_last) rdata_q <= keys_mem[last_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) key_q <= {hi_w, lo_w};
  end

  // Table state: marks, count, walk index, removed count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q   <= '0;
      count_q   <= '0;
      i_q       <= '0;
      removed_q <= '0;
    end else begin
      if (cmd_i.load) begin
        i_q       <= '0;
        removed_q <= '0;
      end
      if (cmd_i.clr_marks) marks_q <= '0;
      if (cmd_i.i_inc) i_q <= i_q + CW'(1);
      if (cmd_i.mark_hit) marks_q[i_idx] <= 1'b1;
      if (cmd_i.append) begin
        marks_q[i_idx] <= 1'b1;
        count_q        <= count_q + CW'(1);
      end
      if (cmd_i.move) begin
        marks_q[last_idx] <= 1'b0;
        marks_q[i_idx]    <= marks_q[last_idx];
        count_q           <= last_w;
        removed_q         <= removed_q + CW'(1);
      end
      if (cmd_i.drop_last) begin
        marks_q[last_idx] <= 1'b0;
        count_q           <= last_w;
        removed_q         <= removed_q + CW'(1);
      end
    end
  end

  assign slot32 = 32'(i_q);
  assign live32 = 32'(count_q);
  assign rem32  = 32'(removed_q);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      live_count_o    <= live32[CNT_W-1:0];
      removed_count_o <= rem32[CNT_W-1:0];
      created_o       <= (cmd_i.res_kind == RES_NEW);
      full_res_o      <= (cmd_i.res_kind == RES_FULL);
      slot_o          <= (cmd_i.res_kind == RES_HIT || cmd_i.res_kind == RES_NEW) ?
                         slot32[SLOT_W-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
